// File: design/commit_tracking_reorder_queue_unit_macros.svh
// Assertion helpers shared by the queue RTL.
// Each macro checks on the rising edge of clk and is quiet while rst_n is low.
`ifndef COMMIT_TRACKING_REORDER_QUEUE_UNIT_MACROS_SVH
`define COMMIT_TRACKING_REORDER_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication
`define CRQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CRQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/crq_pkg.sv
package crq_pkg;

  // Queue geometry
  localparam int DEPTH    = 32;
  localparam int SLOT_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int SUM_W    = SLOT_W + 1;

  // Field widths
  localparam int HANDLE_W = 32;
  localparam int IDX_W    = 63;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 3;
  localparam int ALU_W    = IDX_W + 1;

  // Stream word layouts, padded to whole bytes
  localparam int IN_FIELDS_W  = HANDLE_W + IDX_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = HANDLE_W + IDX_W + STATUS_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND      = 3'd0,
    FN_COMMIT_THRU = 3'd1,
    FN_COMMIT_ONE  = 3'd2,
    FN_FLUSH       = 3'd3,
    FN_SET_HEAD    = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE_OK = 3'd0,
    ST_STEPPED = 3'd1,
    ST_NOTHING = 3'd2,
    ST_REJECT  = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK_RD,
    S_WALK_WR,
    S_FINISH,
    S_RETIRE,
    S_RET_UPD
  } state_t;

  // Control of the shared add/subtract unit
  typedef struct packed {
    logic en;
    logic sub;
  } alu_ctl_t;

  // Slot arithmetic modulo DEPTH, both operands below DEPTH
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                 input logic [SLOT_W-1:0] b);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage

// File: design/commit_tracking_reorder_queue_unit.sv
// Each accepted item passes through decide and finish, then retires committed head
// entries before the next item is taken; a commit or flush also walks its entries,
// skipping those already marked, and output stalls hold the walk and the finish.
// Reset (rst_n low, synchronous) empties the queue, clears all marks and sets the head
// index and slot to zero; handle storage is not cleared.
`include "commit_tracking_reorder_queue_unit_macros.svh"

module commit_tracking_reorder_queue_unit
  import crq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // handle[31:0], index[94:32], zero pad
  input  logic [FUNC_W-1:0]      in_tuser,   // func[2:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // handle[31:0], index[94:32], status[97:95]
  output logic                   out_tlast
);

  state_t                state_r, state_nxt;
  logic [FUNC_W-1:0]     func_r, func_nxt;
  logic [HANDLE_W-1:0]   handle_r, handle_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [SLOT_W-1:0]     i_r, i_nxt;
  logic [SLOT_W-1:0]     end_r, end_nxt;
  logic [CNT_W-1:0]      ret_n_r, ret_n_nxt;

  logic [IDX_W-1:0]      head_index_r, head_index_nxt;
  logic [SLOT_W-1:0]     head_slot_r, head_slot_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [DEPTH-1:0]      marks_r, marks_nxt;

  logic                  pend_valid_r, pend_valid_nxt;
  logic [HANDLE_W-1:0]   pend_handle_r, pend_handle_nxt;
  logic [IDX_W-1:0]      pend_index_r, pend_index_nxt;
  logic [STATUS_W-1:0]   pend_status_r, pend_status_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [HANDLE_W-1:0]   out_handle_r, out_handle_nxt;
  logic [IDX_W-1:0]      out_index_r, out_index_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic                  out_last_r, out_last_nxt;

  alu_ctl_t              alu_ctl;
  logic [ALU_W-1:0]      alu_a, alu_b, alu_res;

  logic                  ram_we, ram_re;
  logic [HANDLE_W-1:0]   ram_rdata;

  logic [IDX_W-1:0]      in_index;
  logic [SLOT_W-1:0]     walk_slot, tail_slot;
  logic                  out_free;
  logic                  past_tail;
  logic                  is_flush;

  assign in_index  = in_tdata[HANDLE_W +: IDX_W];
  assign walk_slot = slot_add(head_slot_r, i_r);
  assign tail_slot = slot_add(head_slot_r, count_r[SLOT_W-1:0]);
  assign out_free  = !out_valid_r || out_tready;
  assign is_flush  = (func_r == FN_FLUSH);
  // Offset from head at or beyond the entry count
  assign past_tail = (|alu_res[IDX_W-1:CNT_W]) || (alu_res[CNT_W-1:0] >= count_r);

  crq_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (DEPTH)
  ) u_handles (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_slot),
    .wdata (handle_r),
    .re    (ram_re),
    .raddr (walk_slot),
    .rdata (ram_rdata)
  );

  crq_alu u_alu (
    .clk   (clk),
    .ctl   (alu_ctl),
    .a     (alu_a),
    .b     (alu_b),
    .res_r (alu_res)
  );

  // Sequencer: next state, queue updates, result staging
  always_comb begin
    state_nxt       = state_r;
    func_nxt        = func_r;
    handle_nxt      = handle_r;
    idx_nxt         = idx_r;
    i_nxt           = i_r;
    end_nxt         = end_r;
    ret_n_nxt       = ret_n_r;
    head_index_nxt  = head_index_r;
    head_slot_nxt   = head_slot_r;
    count_nxt       = count_r;
    marks_nxt       = marks_r;
    pend_valid_nxt  = pend_valid_r;
    pend_handle_nxt = pend_handle_r;
    pend_index_nxt  = pend_index_r;
    pend_status_nxt = pend_status_r;
    out_valid_nxt   = out_tready ? 1'b0 : out_valid_r;
    out_handle_nxt  = out_handle_r;
    out_index_nxt   = out_index_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;
    in_tready       = 1'b0;
    alu_ctl         = '0;
    alu_a           = ALU_W'(head_index_r);
    alu_b           = '0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          func_nxt   = in_tuser;
          handle_nxt = in_tdata[HANDLE_W-1:0];
          idx_nxt    = in_index;
          state_nxt  = S_DECIDE;
          // Tail index for append, offset from head otherwise
          alu_ctl.en = 1'b1;
          if (in_tuser == FN_APPEND) begin
            alu_b = ALU_W'(count_r);
          end else begin
            alu_ctl.sub = 1'b1;
            alu_a       = ALU_W'(in_index);
            alu_b       = ALU_W'(head_index_r);
          end
        end
      end

      S_DECIDE: begin
        state_nxt       = S_FINISH;
        pend_handle_nxt = '0;
        pend_index_nxt  = idx_r;
        case (func_r)
          FN_APPEND: begin
            pend_valid_nxt  = 1'b1;
            pend_handle_nxt = handle_r;
            pend_index_nxt  = alu_res[IDX_W-1:0];
            if (count_r == CNT_W'(DEPTH)) begin
              pend_status_nxt = ST_FULL;
            end else begin
              ram_we               = 1'b1;
              marks_nxt[tail_slot] = 1'b0;
              count_nxt            = count_r + CNT_W'(1);
              pend_status_nxt      = ST_NOTHING;
            end
          end
          FN_COMMIT_THRU, FN_COMMIT_ONE: begin
            if (count_r == '0 || alu_res[ALU_W-1]) begin
              pend_valid_nxt  = 1'b1;
              pend_status_nxt = ST_NOTHING;
            end else if (past_tail) begin
              pend_valid_nxt  = 1'b1;
              pend_status_nxt = ST_REJECT;
            end else begin
              i_nxt     = (func_r == FN_COMMIT_THRU) ? '0 : alu_res[SLOT_W-1:0];
              end_nxt   = alu_res[SLOT_W-1:0];
              state_nxt = S_WALK_RD;
            end
          end
          FN_FLUSH: begin
            if (count_r != '0) begin
              i_nxt     = '0;
              end_nxt   = SLOT_W'(count_r - CNT_W'(1));
              state_nxt = S_WALK_RD;
            end
          end
          FN_SET_HEAD: begin
            pend_valid_nxt = 1'b1;
            if (count_r != '0) begin
              pend_status_nxt = ST_REJECT;
            end else begin
              head_index_nxt  = idx_r;
              pend_status_nxt = ST_NOTHING;
            end
          end
          default: begin
            pend_valid_nxt  = 1'b1;
            pend_status_nxt = ST_REJECT;
          end
        endcase
      end

      S_WALK_RD: begin
        if (marks_r[walk_slot]) begin
          // Skip an entry already released
          if (i_r == end_r) begin
            state_nxt = S_FINISH;
          end else begin
            i_nxt = i_r + SLOT_W'(1);
          end
        end else begin
          ram_re     = 1'b1;
          alu_ctl.en = 1'b1;
          alu_b      = ALU_W'(i_r);
          state_nxt  = S_WALK_WR;
        end
      end

      S_WALK_WR: begin
        if (!pend_valid_r || out_free) begin
          // Advance the staged word to the output, stage this release
          if (pend_valid_r) begin
            out_valid_nxt  = 1'b1;
            out_handle_nxt = pend_handle_r;
            out_index_nxt  = pend_index_r;
            out_status_nxt = pend_status_r;
            out_last_nxt   = 1'b0;
          end
          pend_valid_nxt  = 1'b1;
          pend_handle_nxt = ram_rdata;
          pend_index_nxt  = alu_res[IDX_W-1:0];
          pend_status_nxt = is_flush ? ST_STEPPED : ST_DONE_OK;
          if (!is_flush) begin
            marks_nxt[walk_slot] = 1'b1;
          end
          if (i_r == end_r) begin
            state_nxt = S_FINISH;
          end else begin
            i_nxt     = i_r + SLOT_W'(1);
            state_nxt = S_WALK_RD;
          end
        end
      end

      S_FINISH: begin
        if (out_free) begin
          // Final word of the item, or a plain status word if nothing was staged
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          if (pend_valid_r) begin
            out_handle_nxt = pend_handle_r;
            out_index_nxt  = pend_index_r;
            out_status_nxt = pend_status_r;
          end else begin
            out_handle_nxt = '0;
            out_index_nxt  = is_flush ? '0 : idx_r;
            out_status_nxt = ST_NOTHING;
          end
          pend_valid_nxt = 1'b0;
          if (is_flush) begin
            marks_nxt      = '0;
            count_nxt      = '0;
            head_slot_nxt  = '0;
            head_index_nxt = '0;
          end
          state_nxt = S_RETIRE;
        end
      end

      S_RETIRE: begin
        if (count_r != '0 && marks_r[head_slot_r]) begin
          // Drop one committed head entry
          marks_nxt[head_slot_r] = 1'b0;
          head_slot_nxt          = slot_add(head_slot_r, SLOT_W'(1));
          count_nxt              = count_r - CNT_W'(1);
          ret_n_nxt              = ret_n_r + CNT_W'(1);
        end else begin
          alu_ctl.en = 1'b1;
          alu_b      = ALU_W'(ret_n_r);
          state_nxt  = S_RET_UPD;
        end
      end

      S_RET_UPD: begin
        head_index_nxt = alu_res[IDX_W-1:0];
        ret_n_nxt      = '0;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_n_r      <= '0;
      head_index_r <= '0;
      head_slot_r  <= '0;
      count_r      <= '0;
      marks_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ret_n_r      <= ret_n_nxt;
      head_index_r <= head_index_nxt;
      head_slot_r  <= head_slot_nxt;
      count_r      <= count_nxt;
      marks_r      <= marks_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    func_r        <= func_nxt;
    handle_r      <= handle_nxt;
    idx_r         <= idx_nxt;
    i_r           <= i_nxt;
    end_r         <= end_nxt;
    pend_handle_r <= pend_handle_nxt;
    pend_index_r  <= pend_index_nxt;
    pend_status_r <= pend_status_nxt;
    out_handle_r  <= out_handle_nxt;
    out_index_r   <= out_index_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {OUT_PAD_W'(0), out_status_r, out_index_r, out_handle_r};

  `CRQ_ASSERT_IMP(a_ready_unstaged, in_tready, !pend_valid_r, "ready with a staged word")
  `CRQ_ASSERT_NXT(a_one_item, in_tvalid && in_tready, !in_tready, "second item taken")
  `CRQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "entry count overflow")
  `CRQ_ASSERT_IMP(a_head_retired, (state_r == S_IDLE) && (count_r != '0), !marks_r[head_slot_r], "committed head left unretired")
  `CRQ_ASSERT_IMP(a_empty_clear, (state_r == S_IDLE) && (count_r == '0), marks_r == '0, "marks set on empty queue")

endmodule

// File: design/crq_ram.sv
module crq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/crq_alu.sv
module crq_alu
  import crq_pkg::*;
(
  input  logic             clk,
  input  alu_ctl_t         ctl,
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  output logic [ALU_W-1:0] res_r
);

  logic [ALU_W-1:0] b_op;
  logic [ALU_W-1:0] res_nxt;

  // Add, or subtract by adding the complement
  assign b_op    = ctl.sub ? ~b : b;
  assign res_nxt = a + b_op + ALU_W'(ctl.sub);

  // Hold the result until the next operation
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      res_r <= res_nxt;
    end
  end

endmodule

// File: bench/commit_tracking_reorder_queue_unit_tb.sv
module commit_tracking_reorder_queue_unit_tb;
  import crq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int            HALF_PERIOD = 6;
  localparam int            RESET_CYCLES = 12;
  localparam int            CYCLE_LIMIT = 400000;
  localparam int            SCRIPT_LEN = 25;
  localparam int            RANDOM_WORDS = 200;
  localparam int            DRAIN_CYCLES = 60;
  localparam int            REPORT_MAX = 10;
  localparam logic [IDX_W-1:0] IDX_TOP = '1;
  // Function codes the block does not define
  localparam logic [FUNC_W-1:0] FN_BAD_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_BAD_HI = 3'd7;

  // One released entry as it leaves the block
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [IDX_W-1:0]    index;
    status_t             status;
    logic                last;
  } release_t;

  // One row of the directed script; want is used only where typed is set
  typedef struct {
    logic [FUNC_W-1:0]   fn;
    logic [HANDLE_W-1:0] handle;
    logic [IDX_W-1:0]    index;
    bit                  typed;
    release_t            want;
  } step_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [FUNC_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  // Shadow copy of the queue
  logic [HANDLE_W-1:0] q_handles [DEPTH];
  bit                  q_marks [DEPTH];
  logic [IDX_W-1:0]    q_head_idx;
  int                  q_head_slot;
  int                  q_count;

  release_t release_q [$];
  int       mismatches;
  int       words_sent;
  int       cycle_count;
  bit       gaps_on;

  step_t script [SCRIPT_LEN] = '{
    '{FN_COMMIT_THRU, 32'hDEAD_BEEF, 63'd0, 1'b1, '{32'd0, 63'd0, ST_NOTHING, 1'b1}},
    '{FN_FLUSH, 32'h0, IDX_TOP, 1'b1, '{32'd0, 63'd0, ST_NOTHING, 1'b1}},
    '{FN_BAD_LO, 32'h0, IDX_TOP, 1'b1, '{32'd0, IDX_TOP, ST_REJECT, 1'b1}},
    '{FN_BAD_HI, 32'hFFFF_FFFF, 63'd0, 1'b1, '{32'd0, 63'd0, ST_REJECT, 1'b1}},
    '{FN_COMMIT_ONE, 32'h0, 63'd5, 1'b1, '{32'd0, 63'd5, ST_NOTHING, 1'b1}},
    '{FN_SET_HEAD, 32'h0, IDX_TOP - 63'd1, 1'b1,
      '{32'd0, IDX_TOP - 63'd1, ST_NOTHING, 1'b1}},
    '{FN_APPEND, 32'hFFFF_FFFF, 63'd0, 1'b1,
      '{32'hFFFF_FFFF, IDX_TOP - 63'd1, ST_NOTHING, 1'b1}},
    '{FN_APPEND, 32'h0, 63'd9, 1'b1, '{32'd0, IDX_TOP, ST_NOTHING, 1'b1}},
    '{FN_APPEND, 32'h1234_5678, IDX_TOP, 1'b1,
      '{32'h1234_5678, 63'd0, ST_NOTHING, 1'b1}},
    '{FN_SET_HEAD, 32'h0, 63'd3, 1'b1, '{32'd0, 63'd3, ST_REJECT, 1'b1}},
    '{FN_COMMIT_ONE, 32'h0, 63'd0, 1'b1, '{32'd0, 63'd0, ST_NOTHING, 1'b1}},
    '{FN_COMMIT_ONE, 32'h0, IDX_TOP, 1'b0, '0},
    '{FN_COMMIT_ONE, 32'h0, IDX_TOP, 1'b1, '{32'd0, IDX_TOP, ST_NOTHING, 1'b1}},
    '{FN_COMMIT_THRU, 32'h0, IDX_TOP, 1'b0, '0},
    '{FN_FLUSH, 32'h0, 63'd0, 1'b0, '0},
    '{FN_APPEND, 32'hA5A5_A5A5, 63'd0, 1'b0, '0},
    '{FN_APPEND, 32'h5A5A_5A5A, 63'd0, 1'b0, '0},
    '{FN_APPEND, 32'h0F0F_0F0F, 63'd0, 1'b0, '0},
    '{FN_COMMIT_THRU, 32'h0, 63'd3, 1'b1, '{32'd0, 63'd3, ST_REJECT, 1'b1}},
    '{FN_COMMIT_ONE, 32'h0, 63'd1, 1'b0, '0},
    '{FN_COMMIT_THRU, 32'h0, 63'd2, 1'b0, '0},
    '{FN_APPEND, 32'hC3C3_C3C3, 63'd0, 1'b0, '0},
    '{FN_APPEND, 32'h3C3C_3C3C, 63'd0, 1'b0, '0},
    '{FN_COMMIT_ONE, 32'h0, 63'd4, 1'b0, '0},
    '{FN_FLUSH, 32'h0, 63'd0, 1'b0, '0}
  };

  commit_tracking_reorder_queue_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  function automatic release_t rel(logic [HANDLE_W-1:0] h, logic [IDX_W-1:0] i,
                                   status_t st);
    rel = '{h, i, st, 1'b0};
  endfunction

  // Add an expected word at the tail of the pending list
  function automatic void queue_release(release_t r);
    release_q.insert(release_q.size(), r);
  endfunction

  // Take the oldest expected word off the pending list
  function automatic release_t next_release();
    next_release = release_q[0];
    release_q.delete(0);
  endfunction

  // Mark the entry at offset off and release it unless it was already out
  function automatic void mark_and_release(int off);
    int s;
    s = (q_head_slot + off) % DEPTH;
    if (!q_marks[s]) begin
      q_marks[s] = 1'b1;
      queue_release(rel(q_handles[s], q_head_idx + IDX_W'(off), ST_DONE_OK));
    end
  endfunction

  // Apply one accepted word to the shadow queue and queue up its releases
  function automatic void apply_op(logic [FUNC_W-1:0] fn, logic [HANDLE_W-1:0] h,
                                   logic [IDX_W-1:0] idx);
    logic [IDX_W:0] tail_end;
    int first;
    int off;
    int s;
    first = release_q.size();
    tail_end = {1'b0, q_head_idx} + (IDX_W+1)'(q_count);
    case (fn)
      FN_APPEND: begin
        if (q_count >= DEPTH) begin
          queue_release(rel(h, tail_end[IDX_W-1:0], ST_FULL));
        end else begin
          s = (q_head_slot + q_count) % DEPTH;
          q_handles[s] = h;
          q_marks[s] = 1'b0;
          q_count++;
          queue_release(rel(h, tail_end[IDX_W-1:0], ST_NOTHING));
        end
      end
      FN_COMMIT_THRU, FN_COMMIT_ONE: begin
        if (q_count == 0 || idx < q_head_idx) begin
          queue_release(rel('0, idx, ST_NOTHING));
        end else if ({1'b0, idx} >= tail_end) begin
          queue_release(rel('0, idx, ST_REJECT));
        end else begin
          off = int'(idx - q_head_idx);
          for (int i = (fn == FN_COMMIT_ONE) ? off : 0; i <= off; i++) begin
            mark_and_release(i);
          end
          if (release_q.size() == first) begin
            queue_release(rel('0, idx, ST_NOTHING));
          end
        end
      end
      FN_FLUSH: begin
        for (int i = 0; i < q_count; i++) begin
          s = (q_head_slot + i) % DEPTH;
          if (!q_marks[s]) begin
            queue_release(rel(q_handles[s], q_head_idx + IDX_W'(i), ST_STEPPED));
          end
        end
        foreach (q_marks[j]) q_marks[j] = 1'b0;
        q_count = 0;
        q_head_slot = 0;
        q_head_idx = '0;
        if (release_q.size() == first) begin
          queue_release(rel('0, '0, ST_NOTHING));
        end
      end
      FN_SET_HEAD: begin
        if (q_count != 0) begin
          queue_release(rel('0, idx, ST_REJECT));
        end else begin
          q_head_idx = idx;
          queue_release(rel('0, idx, ST_NOTHING));
        end
      end
      default: begin
        queue_release(rel('0, idx, ST_REJECT));
      end
    endcase
    // Retire committed entries at the head
    while (q_count > 0 && q_marks[q_head_slot]) begin
      q_marks[q_head_slot] = 1'b0;
      q_head_slot = (q_head_slot + 1) % DEPTH;
      q_head_idx = q_head_idx + IDX_W'(1);
      q_count--;
    end
    release_q[release_q.size()-1].last = 1'b1;
  endfunction

  // Present one word from a falling edge and hold it until accepted
  task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [HANDLE_W-1:0] h,
                           input logic [IDX_W-1:0] idx, input bit typed = 1'b0,
                           input release_t want = '0);
    while (gaps_on && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= IN_TDATA_W'({idx, h});
    do @(posedge clk); while (!in_tready);
    apply_op(fn, h, idx);
    // Directed rows with a typed result replace the single predicted one
    if (typed) begin
      release_q.delete(release_q.size() - 1);
      queue_release(want);
    end
    words_sent++;
    @(negedge clk);
  endtask

  function automatic logic [IDX_W-1:0] any_idx();
    any_idx = IDX_W'({$urandom(), $urandom()});
  endfunction

  // Index of a live entry, or anything when the queue is empty
  function automatic logic [IDX_W-1:0] live_idx();
    if (q_count == 0) begin
      live_idx = any_idx();
    end else begin
      live_idx = q_head_idx + IDX_W'($urandom_range(0, q_count - 1));
    end
  endfunction

  // New head: near the wrap point, anywhere, or low
  function automatic logic [IDX_W-1:0] head_pick();
    case ($urandom_range(0, 2))
      0:       head_pick = IDX_TOP - IDX_W'($urandom_range(0, 40));
      1:       head_pick = any_idx();
      default: head_pick = IDX_W'($urandom_range(0, 1000));
    endcase
  endfunction

  // One word of a mixed sequence, weighted toward appends and live commits
  task automatic mixed_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_word(FN_APPEND, $urandom(), any_idx());
    end else if (pick < 60) begin
      send_word(FN_COMMIT_ONE, $urandom(), live_idx());
    end else if (pick < 72) begin
      send_word(FN_COMMIT_THRU, $urandom(), live_idx());
    end else if (pick < 78) begin
      send_word($urandom_range(0, 1) ? FN_COMMIT_ONE : FN_COMMIT_THRU, $urandom(),
                $urandom_range(0, 1) ? any_idx()
                                     : q_head_idx + IDX_W'(q_count + $urandom_range(0, 3)));
    end else if (pick < 86) begin
      send_word(FN_FLUSH, $urandom(), any_idx());
    end else if (pick < 93) begin
      send_word(FN_SET_HEAD, $urandom(), head_pick());
    end else begin
      send_word(FN_BAD_LO + FUNC_W'($urandom_range(0, FN_BAD_HI - FN_BAD_LO)), $urandom(),
                any_idx());
    end
  endtask

  // Stall the result side at random
  always @(negedge clk) begin
    out_tready <= !(gaps_on && $urandom_range(0, 99) < 15);
  end

  // Compare each released word with the oldest pending one
  always @(posedge clk) begin
    release_t got;
    release_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[HANDLE_W-1:0], out_tdata[HANDLE_W +: IDX_W],
              status_t'(out_tdata[HANDLE_W+IDX_W +: STATUS_W]), out_tlast};
      if (release_q.size() == 0) begin
        if (mismatches < REPORT_MAX) begin
          $display("%0t: unexpected word handle=%h index=%h status=%0d last=%0b",
                   $realtime, got.handle, got.index, got.status, got.last);
        end
        mismatches++;
      end else begin
        want = next_release();
        if (got.handle !== want.handle || got.index !== want.index ||
            got.status !== want.status || got.last !== want.last) begin
          if (mismatches < REPORT_MAX) begin
            $display("%0t: mismatch exp handle=%h index=%h status=%0d last=%0b",
                     $realtime, want.handle, want.index, want.status, want.last);
            $display("%0t:          got handle=%h index=%h status=%0d last=%0b",
                     $realtime, got.handle, got.index, got.status, got.last);
          end
          mismatches++;
        end
      end
    end
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    bit fill_next;
    int fill_len;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    mismatches = 0;
    words_sent = 0;
    cycle_count = 0;
    gaps_on    = 1'b1;
    fill_next  = 1'b1;
    foreach (q_marks[j]) q_marks[j] = 1'b0;
    q_head_idx  = '0;
    q_head_slot = 0;
    q_count     = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed script
    foreach (script[r]) begin
      send_word(script[r].fn, script[r].handle, script[r].index, script[r].typed,
                script[r].want);
    end

    // Random sequences: fill bursts and mixed runs, quiet stretch in the middle
    while (words_sent < SCRIPT_LEN + RANDOM_WORDS) begin
      gaps_on = !(words_sent > SCRIPT_LEN + 70 && words_sent < SCRIPT_LEN + 130);
      if (fill_next || $urandom_range(0, 3) == 0) begin
        if (q_count == 0 && $urandom_range(0, 1)) begin
          send_word(FN_SET_HEAD, $urandom(), head_pick());
        end
        fill_len = DEPTH - q_count + $urandom_range(0, 2);
        repeat (fill_len) send_word(FN_APPEND, $urandom(), any_idx());
        fill_next = 1'b0;
      end else begin
        repeat ($urandom_range(6, 14)) mixed_word();
      end
    end
    in_tvalid <= 1'b0;
    gaps_on = 1'b1;

    // Drain, then watch for stray words
    while (release_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
